// ===== hdl/kwm_pkg.sv =====
// kwm_pkg: shared types and codes for the k-way merge engine
package kwm_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_POP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic issue_rd;
		logic do_load;
		logic do_pop;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== hdl/k_way_sorted_merge.sv =====
// k_way_sorted_merge: top level of the k-way merge engine
//
//   channel  handshake            payload
//   in       in_valid / in_stall  command, list_index, value
//   out      out_valid / out_stall out_value, from_list, status, last
//
// a load word passes through the LOAD and EMIT states before the next acceptance
// a pop word passes through SCAN, DRAIN, POP and EMIT; the head scan in SCAN reads one
// list head per cycle through the single element memory read port
// reset clears list pointers and counts at once, no clearing pass
// one word in flight; a new word is taken while a result waits in the output register
module k_way_sorted_merge #(
	parameter int NUM_LISTS   = 8,
	parameter int LIST_DEPTH  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [2:0]         list_index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_value,
	output logic [2:0]         from_list,
	output logic [1:0]         status,
	output logic               last
);

	kwm_pkg::ctl_cmd_t             cmd;
	kwm_pkg::ctl_sts_t             sts;
	logic [$clog2(NUM_LISTS)-1:0]  scan_idx;

	kwm_ctrl #(
		.NUM_LISTS (NUM_LISTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.sts      (sts),
		.cmd      (cmd),
		.scan_idx (scan_idx)
	);

	kwm_datapath #(
		.NUM_LISTS   (NUM_LISTS),
		.LIST_DEPTH  (LIST_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.scan_idx   (scan_idx),
		.list_index (list_index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.from_list  (from_list),
		.status     (status),
		.last       (last)
	);

endmodule

// ===== hdl/kwm_ctrl.sv =====
// kwm_ctrl: sequencing state machine and head scan counter of the merge engine
module kwm_ctrl #(
	parameter int NUM_LISTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  kwm_pkg::ctl_sts_t  sts,
	output kwm_pkg::ctl_cmd_t  cmd,
	output logic [$clog2(NUM_LISTS)-1:0] scan_idx
);

	localparam int LW = $clog2(NUM_LISTS);

	kwm_pkg::state_t state_q;
	kwm_pkg::state_t state_nxt;
	logic [LW-1:0]   scan_q;
	logic [LW-1:0]   scan_nxt;
	logic            scan_last;

	assign scan_last = (scan_q == LW'(NUM_LISTS - 1));
	assign scan_idx  = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kwm_pkg::ST_IDLE;
			scan_q  <= '0;
		end else begin
			state_q <= state_nxt;
			scan_q  <= scan_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		scan_nxt  = scan_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			kwm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					scan_nxt    = '0;
					if (command == kwm_pkg::CMD_POP) begin
						state_nxt = kwm_pkg::ST_SCAN;
					end else begin
						state_nxt = kwm_pkg::ST_LOAD;
					end
				end
			end
			kwm_pkg::ST_LOAD: begin
				cmd.do_load = 1'b1;
				state_nxt   = kwm_pkg::ST_EMIT;
			end
			kwm_pkg::ST_SCAN: begin
				cmd.issue_rd = 1'b1;
				if (scan_last) begin
					state_nxt = kwm_pkg::ST_DRAIN;
				end else begin
					scan_nxt = scan_q + LW'(1);
				end
			end
			kwm_pkg::ST_DRAIN: begin
				state_nxt = kwm_pkg::ST_POP;
			end
			kwm_pkg::ST_POP: begin
				cmd.do_pop = 1'b1;
				state_nxt  = kwm_pkg::ST_EMIT;
			end
			kwm_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = kwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = kwm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/kwm_datapath.sv =====
// kwm_datapath: element memory, list pointers, head compare and output register
module kwm_datapath #(
	parameter int NUM_LISTS   = 8,
	parameter int LIST_DEPTH  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kwm_pkg::ctl_cmd_t  cmd,
	output kwm_pkg::ctl_sts_t  sts,
	input  logic [$clog2(NUM_LISTS)-1:0] scan_idx,
	input  logic [2:0]         list_index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_value,
	output logic [2:0]         from_list,
	output logic [1:0]         status,
	output logic               last
);

	localparam int LW    = $clog2(NUM_LISTS);
	localparam int PW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW    = $clog2(LIST_DEPTH + 1);
	localparam int TW    = $clog2(NUM_LISTS * LIST_DEPTH + 1);
	localparam int SIZE  = NUM_LISTS * LIST_DEPTH;
	localparam int AW    = $clog2(SIZE);

	logic [VALUE_WIDTH-1:0] mem [SIZE];

	logic [2:0]             idx_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [PW-1:0]          rd_q   [NUM_LISTS];
	logic [CW-1:0]          fill_q [NUM_LISTS];
	logic [TW-1:0]          total_q;

	logic                   cand_vld_s1;
	logic [LW-1:0]          cand_list_s1;
	logic [VALUE_WIDTH-1:0] rdata_s1;

	logic                   best_vld_q;
	logic [LW-1:0]          best_list_q;
	logic [VALUE_WIDTH-1:0] best_val_q;

	logic signed [31:0]     res_value_q;
	logic [2:0]             res_list_q;
	logic [1:0]             res_status_q;
	logic                   res_last_q;

	logic                   out_valid_q;
	logic signed [31:0]     out_value_q;
	logic [2:0]             out_list_q;
	logic [1:0]             out_status_q;
	logic                   out_last_q;

	logic [VALUE_WIDTH-1:0] load_val;
	logic signed [31:0]     pop_val;
	logic [LW-1:0]          sel;
	logic [PW-1:0]          rd_sel;
	logic [CW-1:0]          fill_sel;
	logic                   idx_ok;
	logic                   full;
	logic [PW:0]            wsum;
	logic [PW-1:0]          wpos;
	logic [PW-1:0]          rd_next;
	logic [AW-1:0]          base_addr;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic                   take;

	// value width conversion in and out
	generate
		if (VALUE_WIDTH <= 32) begin : g_in_narrow
			assign load_val = value[VALUE_WIDTH-1:0];
		end else begin : g_in_wide
			assign load_val = {{(VALUE_WIDTH-32){value[31]}}, value};
		end
		if (VALUE_WIDTH >= 32) begin : g_out_wide
			assign pop_val = best_val_q[31:0];
		end else begin : g_out_narrow
			assign pop_val = {{(32-VALUE_WIDTH){best_val_q[VALUE_WIDTH-1]}}, best_val_q};
		end
	endgenerate

	// one list select serves scan, load and pop
	always_comb begin
		if (cmd.issue_rd) begin
			sel = scan_idx;
		end else if (cmd.do_load) begin
			sel = LW'(idx_q);
		end else begin
			sel = best_list_q;
		end
	end

	assign rd_sel    = rd_q[sel];
	assign fill_sel  = fill_q[sel];
	assign idx_ok    = (32'(idx_q) < 32'(NUM_LISTS));
	assign full      = !idx_ok || (fill_sel == CW'(LIST_DEPTH));
	assign wsum      = (PW+1)'(rd_sel) + (PW+1)'(fill_sel);
	assign wpos      = (wsum >= (PW+1)'(LIST_DEPTH)) ? PW'(wsum - (PW+1)'(LIST_DEPTH))
	                                                 : PW'(wsum);
	assign rd_next   = (rd_sel == PW'(LIST_DEPTH - 1)) ? '0 : rd_sel + PW'(1);
	assign base_addr = AW'(AW'(sel) * AW'(LIST_DEPTH));
	assign rd_addr   = base_addr + AW'(rd_sel);
	assign wr_addr   = base_addr + AW'(wpos);

	assign take         = cand_vld_s1 &&
	                      (!best_vld_q || ($signed(rdata_s1) < $signed(best_val_q)));
	assign sts.out_free = !out_valid_q || !out_stall;

	// element memory
	always_ff @(posedge clk) begin
		if (cmd.do_load && !full) begin
			mem[wr_addr] <= val_q;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// item capture and candidate tags
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= list_index;
			val_q <= load_val;
		end
		cand_list_s1 <= sel;
		if (take) begin
			best_list_q <= cand_list_s1;
			best_val_q  <= rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_vld_s1 <= 1'b0;
			best_vld_q  <= 1'b0;
		end else begin
			cand_vld_s1 <= cmd.issue_rd && (fill_sel != '0);
			if (cmd.capture) begin
				best_vld_q <= 1'b0;
			end else if (take) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	// list pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LISTS; k++) begin
				rd_q[k]   <= '0;
				fill_q[k] <= '0;
			end
			total_q <= '0;
		end else begin
			if (cmd.do_load && !full) begin
				fill_q[sel] <= fill_sel + CW'(1);
				total_q     <= total_q + TW'(1);
			end
			if (cmd.do_pop && best_vld_q) begin
				rd_q[sel]   <= rd_next;
				fill_q[sel] <= fill_sel - CW'(1);
				total_q     <= total_q - TW'(1);
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.do_load) begin
			res_value_q  <= '0;
			res_list_q   <= '0;
			res_last_q   <= 1'b0;
			res_status_q <= full ? kwm_pkg::STATUS_FULL : kwm_pkg::STATUS_OK;
		end else if (cmd.do_pop) begin
			if (best_vld_q) begin
				res_value_q  <= pop_val;
				res_list_q   <= 3'(best_list_q);
				res_last_q   <= (total_q == TW'(1));
				res_status_q <= kwm_pkg::STATUS_OK;
			end else begin
				res_value_q  <= '0;
				res_list_q   <= '0;
				res_last_q   <= 1'b0;
				res_status_q <= kwm_pkg::STATUS_EMPTY;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q  <= res_value_q;
			out_list_q   <= res_list_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign from_list = out_list_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

endmodule

// ===== sim/kwm_merge_checker.sv =====
// kwm_merge_checker: predicts every merge engine result and compares it with the output channel
module kwm_merge_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               command,
	input  logic [2:0]         list_index,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_value,
	input  logic [2:0]         from_list,
	input  logic [1:0]         status,
	input  logic               last,
	output int                 mismatches,
	output int                 pending,
	output int                 checked,
	output int                 n_dropped,
	output int                 n_empty,
	output int                 n_last
);

	localparam int LISTS = 8;
	localparam int DEPTH = 64;

	typedef struct packed {
		logic signed [31:0] val;
		logic [2:0]         src_list;
		logic [1:0]         status;
		logic               last;
	} merge_word_t;

	logic signed [31:0] list_mem [LISTS][DEPTH];
	int                 head_pos [LISTS];
	int                 fill [LISTS];
	merge_word_t        due_words [$];
	merge_word_t        want, got;

	function automatic merge_word_t merge_step(input logic cmd, input logic [2:0] idx,
			input logic signed [31:0] val);
		merge_word_t r;
		int best;
		int total;
		r = '0;
		best = -1;
		total = 0;
		if (cmd == kwm_pkg::CMD_LOAD) begin
			if (idx >= LISTS || fill[idx] >= DEPTH) begin
				r.status = kwm_pkg::STATUS_FULL;
			end else begin
				list_mem[idx][(head_pos[idx] + fill[idx]) % DEPTH] = val;
				fill[idx]++;
			end
		end else begin
			// smallest head wins, strict compare keeps ties on the lowest list
			for (int k = 0; k < LISTS; k++)
				if (fill[k] != 0 && (best < 0 ||
						list_mem[k][head_pos[k]] < list_mem[best][head_pos[best]]))
					best = k;
			if (best < 0) begin
				r.status = kwm_pkg::STATUS_EMPTY;
			end else begin
				r.val = list_mem[best][head_pos[best]];
				r.src_list = 3'(best);
				head_pos[best] = (head_pos[best] + 1) % DEPTH;
				fill[best]--;
				for (int k = 0; k < LISTS; k++)
					total += fill[k];
				r.last = (total == 0);
			end
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input merge_word_t exp_w,
			input merge_word_t act_w);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected value %0d list %0d status %0d last %0d,", what,
				exp_w.val, exp_w.src_list, exp_w.status, exp_w.last,
				" got value %0d list %0d status %0d last %0d",
				act_w.val, act_w.src_list, act_w.status, act_w.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LISTS; k++) begin
				head_pos[k] = 0;
				fill[k] = 0;
			end
			due_words.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
			n_dropped = 0;
			n_empty = 0;
			n_last = 0;
		end else begin
			// output side first so a word taken this edge cannot cover a stray result
			if (out_valid && !out_stall) begin
				got = '{val: out_value, src_list: from_list, status: status, last: last};
				if (due_words.size() == 0) begin
					note_mismatch("result with nothing due", '0, got);
				end else begin
					want = due_words.pop_front();
					checked++;
					if (got.val !== want.val || got.src_list !== want.src_list ||
							got.status !== want.status || got.last !== want.last)
						note_mismatch("mismatch", want, got);
				end
			end
			if (in_valid && !in_stall) begin
				want = merge_step(command, list_index, value);
				if (want.status == kwm_pkg::STATUS_FULL)
					n_dropped++;
				if (want.status == kwm_pkg::STATUS_EMPTY)
					n_empty++;
				if (want.last)
					n_last++;
				due_words.insert(due_words.size(), want);
			end
			pending = due_words.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// tb: stimulus, idling and verdict for the k-way merge engine
module tb;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               command = kwm_pkg::CMD_LOAD;
	logic [2:0]         list_index = '0;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] out_value;
	logic [2:0]         from_list;
	logic [1:0]         status;
	logic               last;

	int mismatches, pending, checked, n_dropped, n_empty, n_last;
	int words_sent = 0;
	int hold_request = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	always #1 clk = ~clk;

	k_way_sorted_merge i_dut (.*);

	kwm_merge_checker i_check (.*);

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_word(input logic cmd, input logic [2:0] idx,
			input logic signed [31:0] val);
		int g;
		command <= cmd;
		list_index <= idx;
		value <= val;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		g = tx_quiet ? 0 : idle_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (checked == words_sent);
		@(posedge clk);
	endtask

	initial begin : receiver
		int left, n;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				left = hold_request;
				hold_request = 0;
			end
			if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else begin
				n = rx_quiet ? 0 : idle_len();
				out_stall <= (n > 0);
				left = (n > 0) ? n - 1 : 0;
			end
		end
	end

	initial begin : stimulus
		int cnt [8];
		longint next_val [8];
		int total, k, pick, n, loads, phase_end;
		bit narrow;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(kwm_pkg::CMD_POP, 3'd5, 32'sh12345678);
		send_word(kwm_pkg::CMD_LOAD, 3'd7, 32'sh7fffffff);
		send_word(kwm_pkg::CMD_LOAD, 3'd0, 32'sh80000000);
		send_word(kwm_pkg::CMD_LOAD, 3'd3, 32'sd0);
		send_word(kwm_pkg::CMD_LOAD, 3'd5, 32'sd0);
		send_word(kwm_pkg::CMD_LOAD, 3'd3, 32'sd1);
		repeat (5) send_word(kwm_pkg::CMD_POP, 3'd0, 32'sd0);
		send_word(kwm_pkg::CMD_POP, 3'd7, 32'shffffffff);
		send_word(kwm_pkg::CMD_LOAD, 3'd2, -32'sd1);
		send_word(kwm_pkg::CMD_LOAD, 3'd6, 32'sh55555555);
		send_word(kwm_pkg::CMD_LOAD, 3'd1, 32'shaaaaaaaa);
		repeat (3) send_word(kwm_pkg::CMD_POP, 3'd2, 32'sh0f0f0f0f);
		// out of order within one list
		send_word(kwm_pkg::CMD_LOAD, 3'd4, 32'sd10);
		send_word(kwm_pkg::CMD_LOAD, 3'd4, 32'sd5);
		repeat (2) send_word(kwm_pkg::CMD_POP, 3'd4, 32'sd0);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			tx_quiet = (ph == 2);
			rx_quiet = (ph == 2);
			if (ph == 1 || ph == 3)
				hold_request = 400;
			phase_end = words_sent + 400;
			while (words_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					// ascending lists on a random subset, then merge them out
					total = 0;
					narrow = ($urandom_range(0, 2) == 0);
					for (int j = 0; j < 8; j++) begin
						if ($urandom_range(0, 1))
							cnt[j] = ($urandom_range(0, 19) == 0) ?
								$urandom_range(20, 64) : $urandom_range(1, 6);
						else
							cnt[j] = 0;
						if (narrow)
							next_val[j] = $urandom_range(0, 3);
						else if ($urandom_range(0, 9) == 0)
							next_val[j] = -64'sd2147483648;
						else
							next_val[j] = longint'(int'($urandom));
						total += cnt[j];
					end
					if (total == 0) begin
						cnt[$urandom_range(0, 7)] = 1;
						total = 1;
					end
					loads = total;
					while (total > 0) begin
						do
							k = $urandom_range(0, 7);
						while (cnt[k] == 0);
						send_word(kwm_pkg::CMD_LOAD, 3'(k), 32'(next_val[k]));
						cnt[k]--;
						total--;
						next_val[k] += narrow ? $urandom_range(0, 1) :
							$urandom_range(0, 1 << $urandom_range(0, 30));
						if (next_val[k] > 64'sd2147483647)
							next_val[k] = 64'sd2147483647;
					end
					repeat (loads + 1) send_word(kwm_pkg::CMD_POP, 3'($urandom), $urandom);
				end else if (pick < 65) begin
					// overrun one list past its depth
					k = $urandom_range(0, 7);
					next_val[k] = longint'(int'($urandom)) >>> 1;
					repeat (66) begin
						send_word(kwm_pkg::CMD_LOAD, 3'(k), 32'(next_val[k]));
						next_val[k] += $urandom_range(0, 1000);
					end
					repeat (67) send_word(kwm_pkg::CMD_POP, 3'($urandom), $urandom);
				end else begin
					n = $urandom_range(1, 12);
					loads = 0;
					repeat (n) begin
						if ($urandom_range(0, 1)) begin
							send_word(kwm_pkg::CMD_LOAD, 3'($urandom), $urandom);
							loads++;
						end else begin
							send_word(kwm_pkg::CMD_POP, 3'($urandom), $urandom);
						end
					end
					repeat (loads) send_word(kwm_pkg::CMD_POP, 3'($urandom), $urandom);
				end
			end
			settle();
		end

		repeat (30) @(posedge clk);
		$display("tb: %0d words driven, %0d results matched, %0d mismatches", words_sent,
			checked, mismatches);
		$display("tb: %0d loads dropped on a full list, %0d pops with nothing left,", n_dropped,
			n_empty, " %0d pops that emptied every list", n_last);
		if (mismatches == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#10000000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/kwm_pkg.sv
hdl/kwm_ctrl.sv
hdl/kwm_datapath.sv
hdl/k_way_sorted_merge.sv
sim/kwm_merge_checker.sv
sim/tb.sv
